>>> design/rntbc_pkg.sv
// ----------------------------------------------------------------------------
// rntbc_pkg: shared types and constants of the tiered replay filter
// Transaction payloads, verdict and register codes, FNV-1a constants and the
// hash lane control group.
// ----------------------------------------------------------------------------
package rntbc_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic [63:0] nonce;
    logic [63:0] packet_time;
    logic [63:0] now_seconds;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0] verdict;
    logic       degraded_now;
  } out_item_t;

  // Control group from the sequencer to every hash lane.
  typedef struct packed {
    logic load;
    logic fnv_step;
    logic mod_step;
  } hash_ctrl_t;

  // Verdict codes.
  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_STALE  = 2'd1;
  localparam logic [1:0] VERDICT_REPLAY = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGRADED_FILL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_FILL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FILL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEVATED_FILL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ELEV    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_NORMAL  = 3'd6;

  // Register reset values.
  localparam logic [6:0]  RST_DEGRADED_FILL  = 7'd70;
  localparam logic [6:0]  RST_EMERGENCY_FILL = 7'd90;
  localparam logic [6:0]  RST_HIGH_FILL      = 7'd80;
  localparam logic [6:0]  RST_ELEVATED_FILL  = 7'd50;
  localparam logic [11:0] RST_WINDOW_HIGH    = 12'd1;
  localparam logic [11:0] RST_WINDOW_ELEV    = 12'd2;
  localparam logic [11:0] RST_WINDOW_NORMAL  = 12'd5;

  // Recovery from degraded mode.
  localparam logic [6:0]  CLEAR_FILL_PCT = 7'd30;
  localparam logic [63:0] CLEAR_HOLD_SEC = 64'd30;

  // FNV-1a 64-bit constants.
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // Multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64, as shifts and adds.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

>>> design/replay_nonce_tiered_bloom_check.sv
// ----------------------------------------------------------------------------
// replay_nonce_tiered_bloom_check: tiered Bloom filter replay check
// Stale and replay screening of packet nonces over three bit stores.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. An accepted packet is hashed
// byte-serially with FNV-1a in HASH_COUNT parallel lanes; a stale packet
// then goes straight to the result. Otherwise byte-wise reduction of the
// hashes to store positions follows, a quotient step and a remainder step
// per hash byte, then probing and inserting on the single port of each
// store, one mode update and the loading of the result, which waits while
// the previous result is still stalled. After reset the stores are zeroed,
// one bit a cycle in parallel, up to the size of the largest store,
// max(TIERn_CAPACITY*BITS_PER_ENTRY) bits (40960 by default), and in that
// time no packet is taken; configuration writes are taken at any time.
module replay_nonce_tiered_bloom_check
  import rntbc_pkg::*;
#(
  parameter int TIER1_CAPACITY = 1024,
  parameter int TIER2_CAPACITY = 4096,
  parameter int TIER3_CAPACITY = 4096,
  parameter int HASH_COUNT     = 4,
  parameter int BITS_PER_ENTRY = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int T1_BITS = TIER1_CAPACITY * BITS_PER_ENTRY;
  localparam int T2_BITS = TIER2_CAPACITY * BITS_PER_ENTRY;
  localparam int T3_BITS = TIER3_CAPACITY * BITS_PER_ENTRY;
  localparam int MAXB12  = (T1_BITS > T2_BITS) ? T1_BITS : T2_BITS;
  localparam int MAX_BITS = (MAXB12 > T3_BITS) ? MAXB12 : T3_BITS;
  localparam int CW  = $clog2(MAX_BITS);
  localparam int P1W = $clog2(T1_BITS);
  localparam int P2W = $clog2(T2_BITS);
  localparam int P3W = $clog2(T3_BITS);
  localparam int LW  = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HASH   = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_PROBE  = 3'd4;
  localparam logic [2:0] ST_WRITE  = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]  state;
  logic [5:0]  step;
  logic [CW-1:0] clr_cnt;

  logic [6:0]  degraded_pct, emergency_pct, high_pct, elevated_pct;
  logic [11:0] win_high, win_elev, win_normal;

  logic [63:0] nonce_sh, ptime, now_s;
  logic [63:0] diff;
  logic [11:0] win;
  logic [31:0] tier2_count;
  logic        degraded;
  logic [63:0] degraded_since;
  logic [1:0]  verdict;
  logic        all1, all2, all3;

  hash_ctrl_t  hctrl;
  logic [P1W-1:0] pos1 [HASH_COUNT];
  logic [P2W-1:0] pos2 [HASH_COUNT];
  logic [P3W-1:0] pos3 [HASH_COUNT];

  logic           we1, we2, we3, wbit;
  logic [P1W-1:0] addr1;
  logic [P2W-1:0] addr2;
  logic [P3W-1:0] addr3;
  logic           rd1, rd2, rd3;

  logic [39:0] cnt100;
  logic        accept;
  logic [LW-1:0] lane;
  logic        fin1, fin2, fin3;

  // Fill comparison: count*100 >= pct*capacity.
  function automatic logic fill_ge(input logic [39:0] c100, input logic [6:0] pct);
    fill_ge = c100 >= (40'(pct) * 40'(TIER2_CAPACITY));
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign cnt100   = 40'(tier2_count) * 40'd100;
  assign lane     = step[LW-1:0];

  // Hash lane control.
  assign hctrl.load     = accept;
  assign hctrl.fnv_step = (state == ST_HASH);
  assign hctrl.mod_step = (state == ST_MOD);

  // Hash lanes, one per hash function.
  for (genvar g = 0; g < HASH_COUNT; g++) begin : g_lane
    rntbc_hash #(
      .SEED    (g),
      .T1_BITS (T1_BITS),
      .T2_BITS (T2_BITS),
      .T3_BITS (T3_BITS)
    ) u_hash (
      .clk        (clk),
      .ctrl       (hctrl),
      .nonce_byte (nonce_sh[7:0]),
      .pos1       (pos1[g]),
      .pos2       (pos2[g]),
      .pos3       (pos3[g])
    );
  end

  // Store port selection: clearing pass, probe reads or inserts.
  always_comb begin
    wbit = (state != ST_CLEAR);
    if (state == ST_CLEAR) begin
      addr1 = clr_cnt[P1W-1:0];
      addr2 = clr_cnt[P2W-1:0];
      addr3 = clr_cnt[P3W-1:0];
      we1   = {1'b0, clr_cnt} < (CW+1)'(T1_BITS);
      we2   = {1'b0, clr_cnt} < (CW+1)'(T2_BITS);
      we3   = {1'b0, clr_cnt} < (CW+1)'(T3_BITS);
    end else begin
      addr1 = pos1[lane];
      addr2 = pos2[lane];
      addr3 = pos3[lane];
      we1   = (state == ST_WRITE);
      we2   = (state == ST_WRITE);
      we3   = (state == ST_WRITE) && degraded;
    end
  end

  rntbc_ram #(.WIDTH(1), .DEPTH(T1_BITS)) u_tier1 (
    .clk(clk), .we(we1), .addr(addr1), .wdata(wbit), .rdata(rd1)
  );
  rntbc_ram #(.WIDTH(1), .DEPTH(T2_BITS)) u_tier2 (
    .clk(clk), .we(we2), .addr(addr2), .wdata(wbit), .rdata(rd2)
  );
  rntbc_ram #(.WIDTH(1), .DEPTH(T3_BITS)) u_tier3 (
    .clk(clk), .we(we3), .addr(addr3), .wdata(wbit), .rdata(rd3)
  );

  // Probe results including the last read that is arriving now.
  assign fin1 = all1 && rd1;
  assign fin2 = all2 && rd2;
  assign fin3 = all3 && rd3;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      degraded_pct  <= RST_DEGRADED_FILL;
      emergency_pct <= RST_EMERGENCY_FILL;
      high_pct      <= RST_HIGH_FILL;
      elevated_pct  <= RST_ELEVATED_FILL;
      win_high      <= RST_WINDOW_HIGH;
      win_elev      <= RST_WINDOW_ELEV;
      win_normal    <= RST_WINDOW_NORMAL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEGRADED_FILL:  degraded_pct  <= cfg_data[6:0];
        CFG_EMERGENCY_FILL: emergency_pct <= cfg_data[6:0];
        CFG_HIGH_FILL:      high_pct      <= cfg_data[6:0];
        CFG_ELEVATED_FILL:  elevated_pct  <= cfg_data[6:0];
        CFG_WINDOW_HIGH:    win_high      <= cfg_data;
        CFG_WINDOW_ELEV:    win_elev      <= cfg_data;
        CFG_WINDOW_NORMAL:  win_normal    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet payload, time difference and window.
  always_ff @(posedge clk) begin
    if (accept) begin
      nonce_sh <= in_data.nonce;
      ptime    <= in_data.packet_time;
      now_s    <= in_data.now_seconds;
    end else if (state == ST_HASH) begin
      nonce_sh <= nonce_sh >> 8;
    end
    if (state == ST_HASH && step == 6'd0) begin
      diff <= (now_s > ptime) ? (now_s - ptime) : (ptime - now_s);
      if (fill_ge(cnt100, emergency_pct))     win <= '0;
      else if (fill_ge(cnt100, high_pct))     win <= win_high;
      else if (fill_ge(cnt100, elevated_pct)) win <= win_elev;
      else                                    win <= win_normal;
    end
  end

  // Sequencer, filter state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      step           <= '0;
      clr_cnt        <= '0;
      tier2_count    <= '0;
      degraded       <= 1'b0;
      degraded_since <= '0;
      out_valid      <= 1'b0;
      verdict        <= VERDICT_ACCEPT;
      all1           <= 1'b1;
      all2           <= 1'b1;
      all3           <= 1'b1;
    end else begin
      if (out_valid && !out_stall && state != ST_FINISH) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if ({1'b0, clr_cnt} == (CW+1)'(MAX_BITS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          step <= '0;
          if (accept) state <= ST_HASH;
        end
        ST_HASH: begin
          step <= step + 1'b1;
          if (step == 6'd7) begin
            step <= '0;
            if (diff > {52'd0, win}) begin
              verdict <= VERDICT_STALE;
              state   <= ST_FINISH;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          step <= step + 1'b1;
          if (step == 6'd15) begin
            step  <= '0;
            all1  <= 1'b1;
            all2  <= 1'b1;
            all3  <= 1'b1;
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          step <= step + 1'b1;
          if (step != 6'd0) begin
            all1 <= fin1;
            all2 <= fin2;
            all3 <= fin3;
          end
          if (step == 6'(HASH_COUNT)) begin
            step <= '0;
            if (fin1 || fin2 || (degraded && fin3)) begin
              verdict <= VERDICT_REPLAY;
              state   <= ST_FINISH;
            end else begin
              verdict <= VERDICT_ACCEPT;
              if (tier2_count != 32'hFFFF_FFFF) tier2_count <= tier2_count + 1'b1;
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          step <= step + 1'b1;
          if (step == 6'(HASH_COUNT - 1)) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          // Mode update on the count after this insert.
          if (!degraded && fill_ge(cnt100, degraded_pct)) begin
            degraded       <= 1'b1;
            degraded_since <= now_s;
          end else if (degraded && !fill_ge(cnt100, CLEAR_FILL_PCT)) begin
            if ((now_s - degraded_since) >= CLEAR_HOLD_SEC) degraded <= 1'b0;
          end else if (degraded) begin
            degraded_since <= now_s;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload, loaded as the transaction completes.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      out_data.verdict      <= verdict;
      out_data.degraded_now <= degraded;
    end
  end

endmodule

>>> design/rntbc_ram.sv
// ----------------------------------------------------------------------------
// rntbc_ram: generic single-port synchronous RAM
// One access a cycle, either a write or a read with registered data.
// ----------------------------------------------------------------------------
module rntbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the registered output.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/rntbc_hash.sv
// ----------------------------------------------------------------------------
// rntbc_hash: one FNV-1a hash lane with byte-wise modular reduction
// Hashes the nonce one byte a cycle, then reduces the hash modulo the size
// of each of the three stores, each hash byte in a quotient and a remainder step.
// ----------------------------------------------------------------------------
module rntbc_hash
  import rntbc_pkg::*;
#(
  parameter int SEED    = 0,
  parameter int T1_BITS = 10240,
  parameter int T2_BITS = 40960,
  parameter int T3_BITS = 40960
) (
  input  logic                       clk,
  input  hash_ctrl_t                 ctrl,
  input  logic [7:0]                 nonce_byte,
  output logic [$clog2(T1_BITS)-1:0] pos1,
  output logic [$clog2(T2_BITS)-1:0] pos2,
  output logic [$clog2(T3_BITS)-1:0] pos3
);

  localparam int P1W = $clog2(T1_BITS);
  localparam int P2W = $clog2(T2_BITS);
  localparam int P3W = $clog2(T3_BITS);

  // Partial remainder with the next hash byte appended, and the shift of
  // the reciprocal that gives an exact quotient for values of that width.
  localparam int N1W = P1W + 8;
  localparam int N2W = P2W + 8;
  localparam int N3W = P3W + 8;
  localparam int S1  = N1W + P1W;
  localparam int S2  = N2W + P2W;
  localparam int S3  = N3W + P3W;
  localparam longint unsigned R1 =
    ((64'd1 << S1) + 64'(T1_BITS) - 64'd1) / 64'(T1_BITS);
  localparam longint unsigned R2 =
    ((64'd1 << S2) + 64'(T2_BITS) - 64'd1) / 64'(T2_BITS);
  localparam longint unsigned R3 =
    ((64'd1 << S3) + 64'(T3_BITS) - 64'd1) / 64'(T3_BITS);
  localparam logic [N1W:0] RC1 = R1[N1W:0];
  localparam logic [N2W:0] RC2 = R2[N2W:0];
  localparam logic [N3W:0] RC3 = R3[N3W:0];

  logic [63:0]      h;
  logic             phase;
  logic [N1W-1:0]   t1, rem1;
  logic [N2W-1:0]   t2, rem2;
  logic [N3W-1:0]   t3, rem3;
  logic [2*N1W:0]   prod1;
  logic [2*N2W:0]   prod2;
  logic [2*N3W:0]   prod3;
  logic [7:0]       q1, q2, q3;

  // Append the next hash byte, estimate the quotient by reciprocal
  // multiplication and take the remainder with the registered quotient.
  always_comb begin
    t1    = {pos1, h[63:56]};
    t2    = {pos2, h[63:56]};
    t3    = {pos3, h[63:56]};
    prod1 = (2*N1W+1)'(t1) * (2*N1W+1)'(RC1);
    prod2 = (2*N2W+1)'(t2) * (2*N2W+1)'(RC2);
    prod3 = (2*N3W+1)'(t3) * (2*N3W+1)'(RC3);
    rem1  = t1 - (N1W)'(q1) * (N1W)'(T1_BITS);
    rem2  = t2 - (N2W)'(q2) * (N2W)'(T2_BITS);
    rem3  = t3 - (N3W)'(q3) * (N3W)'(T3_BITS);
  end

  // Hash register, quotients and remainders.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      h     <= FNV_BASIS ^ 64'(SEED);
      pos1  <= '0;
      pos2  <= '0;
      pos3  <= '0;
      phase <= 1'b0;
    end else if (ctrl.fnv_step) begin
      h <= fnv_mul(h ^ {56'd0, nonce_byte});
    end else if (ctrl.mod_step) begin
      if (!phase) begin
        q1    <= prod1[S1 +: 8];
        q2    <= prod2[S2 +: 8];
        q3    <= prod3[S3 +: 8];
        phase <= 1'b1;
      end else begin
        h     <= h << 8;
        pos1  <= rem1[P1W-1:0];
        pos2  <= rem2[P2W-1:0];
        pos3  <= rem3[P3W-1:0];
        phase <= 1'b0;
      end
    end
  end

endmodule

>>> design/rntbc_check.sv
// ----------------------------------------------------------------------------
// rntbc_check: port-level checker for the replay filter
// Watches the handshakes and the result payload of the top level.
// ----------------------------------------------------------------------------
module rntbc_check
  import rntbc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // The block works on one transaction at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in progress");

  // No packet is taken while the stores are being cleared after reset.
  a_clear: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open straight after reset");

  // Only defined verdict codes are shown.
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.verdict == VERDICT_ACCEPT ||
                   out_data.verdict == VERDICT_STALE ||
                   out_data.verdict == VERDICT_REPLAY))
    else $error("undefined verdict code");

endmodule

bind replay_nonce_tiered_bloom_check rntbc_check u_rntbc_check (.*);
